// ===== rtl/hee_pkg.sv =====
// ----------------------------------------------------------------------------
// hee_pkg
// shared types and constants of the html entity escaper
// ----------------------------------------------------------------------------
package hee_pkg;

	// register indexes on the configuration port
	localparam int unsigned CFG_INDEX_W = 2;
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_OUTPUT_CAPACITY      = 2'd0,
		CFG_NEWLINE_AS_BREAK_TAG = 2'd1
	} hee_cfg_index_t;

	localparam int unsigned CFG_DATA_W        = 16;
	localparam int unsigned BUDGET_W          = 16;
	localparam logic [BUDGET_W-1:0] CAPACITY_RESET = 16'd4096;

	// longest expansion of one byte, and width of a length count
	localparam int unsigned MAX_EXPAND = 6;
	localparam int unsigned LEN_W      = 3;

	localparam int unsigned HEE_QUEUE_DEPTH = 4;

	// one queued item: expansion characters plus terminator request
	typedef struct packed {
		logic [MAX_EXPAND-1:0][7:0] chars;
		logic [LEN_W-1:0]           len;
		logic                       term;
		logic                       trunc;
	} hee_entry_t;

endpackage

// ===== rtl/hee_front.sv =====
// ----------------------------------------------------------------------------
// hee_front
// accepts text bytes, classifies them, keeps the output budget and queues
// the expansion of each byte that fits the budget, and the end_of_text terminator
// ----------------------------------------------------------------------------
module hee_front import hee_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            text_byte,
	input  logic                  end_of_text,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  cfg_valid,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  queue_full,
	output logic                  push,
	output hee_entry_t            push_entry
);

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_VT    = 8'h0b;
	localparam logic [7:0] CH_FF    = 8'h0c;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	logic [BUDGET_W-1:0] capacity_q;
	logic                nl_break_q;
	logic [BUDGET_W-1:0] budget_q;
	logic                stopped_q;

	logic [MAX_EXPAND-1:0][7:0] chars;
	logic [LEN_W-1:0]           len;
	logic                       hund;
	logic [6:0]                 rest;
	logic [14:0]                tens_prod;
	logic [3:0]                 tens;
	logic [3:0]                 ones;
	logic [6:0]                 tens_x10;
	logic                       fits;
	logic                       stop_now;
	logic                       accept;

	// decimal digits of a code below 127: tens by reciprocal multiply
	always_comb begin
		hund      = (text_byte >= 8'd100);
		rest      = hund ? 7'(text_byte - 8'd100) : text_byte[6:0];
		tens_prod = 15'(rest) * 15'd205;
		tens      = tens_prod[14:11];
		tens_x10  = 7'(tens) * 7'd10;
		ones      = 4'(rest - tens_x10);
	end

	// byte classes
	always_comb begin
		chars = '0;
		len   = '0;
		if (text_byte == CH_LF) begin
			if (nl_break_q) begin
				chars[0] = "<";
				chars[1] = "B";
				chars[2] = "R";
				chars[3] = ">";
				len      = 3'd4;
			end else begin
				chars[0] = CH_LF;
				len      = 3'd1;
			end
		end else if (text_byte == CH_TAB) begin
			chars[0] = CH_TAB;
			len      = 3'd1;
		end else if (text_byte == CH_SPACE || text_byte == CH_VT ||
		             text_byte == CH_FF || text_byte == CH_CR) begin
			chars[0] = CH_SPACE;
			len      = 3'd1;
		end else if (text_byte < 8'd32 || text_byte > 8'd126) begin
			len = '0;
		end else if ((text_byte >= "0" && text_byte <= "9") ||
		             (text_byte >= "A" && text_byte <= "Z") ||
		             (text_byte >= "a" && text_byte <= "z")) begin
			chars[0] = text_byte;
			len      = 3'd1;
		end else begin
			chars[0] = "&";
			case (text_byte)
				"&": begin
					chars[1] = "a"; chars[2] = "m"; chars[3] = "p"; chars[4] = ";";
					len      = 3'd5;
				end
				"<": begin
					chars[1] = "l"; chars[2] = "t"; chars[3] = ";";
					len      = 3'd4;
				end
				">": begin
					chars[1] = "g"; chars[2] = "t"; chars[3] = ";";
					len      = 3'd4;
				end
				"\"": begin
					chars[1] = "q"; chars[2] = "u"; chars[3] = "o"; chars[4] = "t";
					chars[5] = ";";
					len      = 3'd6;
				end
				"'": begin
					chars[1] = "a"; chars[2] = "p"; chars[3] = "o"; chars[4] = "s";
					chars[5] = ";";
					len      = 3'd6;
				end
				default: begin
					chars[1] = "#";
					if (hund) begin
						chars[2] = "1";
						chars[3] = CH_ZERO + 8'(tens);
						chars[4] = CH_ZERO + 8'(ones);
						chars[5] = ";";
						len      = 3'd6;
					end else begin
						chars[2] = CH_ZERO + 8'(tens);
						chars[3] = CH_ZERO + 8'(ones);
						chars[4] = ";";
						len      = 3'd5;
					end
				end
			endcase
		end
	end

	// budget check: one unit always held back for the terminator
	assign fits     = !stopped_q && (len != '0) && (budget_q > BUDGET_W'(len));
	assign stop_now = stopped_q || ((len != '0) && !fits);

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		push_entry.chars = chars;
		push_entry.len   = fits ? len : '0;
		push_entry.term  = end_of_text;
		push_entry.trunc = stop_now;
	end
	assign push = accept && (fits || end_of_text);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
			nl_break_q <= 1'b0;
			budget_q   <= CAPACITY_RESET;
			stopped_q  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_OUTPUT_CAPACITY: begin
					capacity_q <= cfg_data;
					budget_q   <= cfg_data;
					stopped_q  <= 1'b0;
				end
				CFG_NEWLINE_AS_BREAK_TAG: begin
					nl_break_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (end_of_text) begin
				budget_q  <= capacity_q;
				stopped_q <= 1'b0;
			end else begin
				if (fits) begin
					budget_q <= budget_q - BUDGET_W'(len);
				end
				stopped_q <= stop_now;
			end
		end
	end

endmodule

// ===== rtl/hee_fifo.sv =====
// ----------------------------------------------------------------------------
// hee_fifo
// short queue of expanded items between the front and the back
// ----------------------------------------------------------------------------
module hee_fifo import hee_pkg::*; #(
	parameter int unsigned DEPTH = HEE_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  hee_entry_t push_entry,
	input  logic       pop,
	output hee_entry_t head_entry,
	output logic       not_empty,
	output logic       full
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	hee_entry_t       slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head_entry = slots_q[rd_ptr_q];
	assign not_empty  = (count_q != '0);
	assign full       = (count_q == CNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/hee_back.sv =====
// ----------------------------------------------------------------------------
// hee_back
// walks the queued item one character per beat into the output register
// ----------------------------------------------------------------------------
module hee_back import hee_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  hee_entry_t head_entry,
	input  logic       head_valid,
	output logic       pop,
	output logic [7:0] out_char,
	output logic       last_of_run,
	output logic       truncated,
	output logic       out_valid,
	input  logic       out_ready
);

	logic [LEN_W-1:0] idx_q;
	logic             out_valid_q;
	logic [7:0]       char_q;
	logic             last_q;
	logic             trunc_q;

	logic             advance;
	logic             is_expand;
	logic             is_last;
	logic [7:0]       next_char;

	assign advance   = !out_valid_q || out_ready;
	assign is_expand = (idx_q < head_entry.len);
	assign is_last   = head_entry.term ? (idx_q == head_entry.len)
	                                   : (idx_q + 1'b1 == head_entry.len);
	assign next_char = is_expand ? head_entry.chars[idx_q] : 8'h00;
	assign pop       = advance && head_valid && is_last;

	always_ff @(posedge clk) begin
		if (advance && head_valid) begin
			char_q  <= next_char;
			last_q  <= is_last;
			trunc_q <= !is_expand && head_entry.trunc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (advance) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= is_last ? '0 : idx_q + 1'b1;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_char    = char_q;
	assign last_of_run = last_q;
	assign truncated   = trunc_q;

endmodule

// ===== rtl/html_entity_escaper.sv =====
// ----------------------------------------------------------------------------
// html_entity_escaper
// streams text bytes into their html-safe form with an output budget
// ----------------------------------------------------------------------------
// each accepted byte turns into zero to six output characters, and the byte
// flagged end_of_text adds a 0 terminator whose truncated bit tells whether
// the budget cut the text short; an item thus gives 0 to 7 output beats.
// the input side takes one byte per cycle as long as the item queue has room
// (QUEUE_DEPTH entries); the output side gives one character per cycle
// while out_ready is high, so the sustained rate is set by the output
// register. bytes that expand to nothing and do not end the text never
// reach the queue.
// output_capacity (register 0) also restarts the budget when written;
// newline_as_break_tag (register 1) picks "<BR>" or a plain newline.
// the user must write configuration only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module html_entity_escaper import hee_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = HEE_QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input beats
	input  logic [7:0]             text_byte,
	input  logic                   end_of_text,
	input  logic                   in_valid,
	output logic                   in_ready,
	// output beats
	output logic [7:0]             out_char,
	output logic                   last_of_run,
	output logic                   truncated,
	output logic                   out_valid,
	input  logic                   out_ready,
	// register writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	hee_entry_t push_entry;
	hee_entry_t head_entry;
	logic       push;
	logic       pop;
	logic       head_valid;
	logic       queue_full;

	// register writes are always accepted
	assign cfg_ready = 1'b1;

	// front: classify, budget check, queue the expansion
	hee_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_byte  (text_byte),
		.end_of_text(end_of_text),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// decouples byte intake from character output
	hee_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head_entry(head_entry),
		.not_empty (head_valid),
		.full      (queue_full)
	);

	// back: one character per beat, terminator last
	hee_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_entry (head_entry),
		.head_valid (head_valid),
		.pop        (pop),
		.out_char   (out_char),
		.last_of_run(last_of_run),
		.truncated  (truncated),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);

endmodule
